// ----- src/mks_pkg.sv -----
`timescale 1ns / 1ps

package mks_pkg;

  localparam int TickW  = 10;
  localparam int ColW   = 4;
  localparam int CharW  = 8;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_SETTLE   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_BEEP     = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_POLL     = 2'd3;

  localparam logic [TickW-1:0] SETTLE_RST   = 10'd10;
  localparam logic [TickW-1:0] DEBOUNCE_RST = 10'd10;
  localparam logic [TickW-1:0] BEEP_RST     = 10'd100;
  localparam logic [TickW-1:0] POLL_RST     = 10'd20;

  localparam logic [CharW-1:0] NO_KEY   = 8'hFF;
  localparam logic [ColW-1:0]  ROWS_OFF = 4'hF;

  typedef enum logic [1:0] {
    PH_SETTLE,
    PH_DEBOUNCE,
    PH_BEEP,
    PH_RELEASE
  } phase_t;

  typedef struct packed {
    logic [TickW-1:0] settle_ticks;
    logic [TickW-1:0] debounce_ticks;
    logic [TickW-1:0] beep_ticks;
    logic [TickW-1:0] release_poll_ticks;
  } cfg_t;

  typedef struct packed {
    logic [ColW-1:0]  row_drive;
    logic             beep_on;
    logic             pass_done;
    logic [CharW-1:0] key_char;
  } res_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] code;
  } col_code_t;

  // single column 0..3, column pairs 4..7 (0+1, 1+2, 0+2, 0+3), anything else no key
  function automatic col_code_t decode_cols(input logic [ColW-1:0] c);
    col_code_t r;
    r.hit = 1'b1;
    unique case (c)
      4'hE:    r.code = 3'd0;
      4'hD:    r.code = 3'd1;
      4'hB:    r.code = 3'd2;
      4'h7:    r.code = 3'd3;
      4'hC:    r.code = 3'd4;
      4'h9:    r.code = 3'd5;
      4'hA:    r.code = 3'd6;
      4'h6:    r.code = 3'd7;
      default: begin
        r.hit  = 1'b0;
        r.code = 3'd0;
      end
    endcase
    return r;
  endfunction

  function automatic logic [CharW-1:0] key_lookup(input logic [1:0] row,
                                                  input logic [1:0] col);
    logic [CharW-1:0] ch;
    unique case ({row, col})
      4'h0: ch = "1";
      4'h1: ch = "2";
      4'h2: ch = "3";
      4'h3: ch = "*";
      4'h4: ch = "4";
      4'h5: ch = "5";
      4'h6: ch = "6";
      4'h7: ch = "0";
      4'h8: ch = "7";
      4'h9: ch = "8";
      4'hA: ch = "9";
      4'hB: ch = "#";
      4'hC: ch = "*";
      4'hD: ch = "0";
      4'hE: ch = "#";
      default: ch = "#";
    endcase
    return ch;
  endfunction

endpackage

// ----- src/matrix_keypad_scanner.sv -----
`timescale 1ns / 1ps

// 4x4 matrix keypad scanner with debounce. Each input item is one 1 ms tick
// carrying the sampled column levels (active low); each item yields exactly
// one result item with the row drive for that tick, the beeper state, a
// pass-done flag and the last confirmed key character of the pass (255 when
// none). An item is taken every cycle: the scan state advances in one pass
// of logic and the result sits in an output register, so input is accepted
// whenever that register is empty or being emptied. Timing registers
// (settle, debounce, beep, release poll) are written through the cfg port,
// index 0..3; the user must write them only while idle (not enforced).

module matrix_keypad_scanner #(
  parameter int ROW_COUNT = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mks_pkg::ColW-1:0]      in_col_sample,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mks_pkg::ColW-1:0]      out_row_drive,
  output logic                          out_beep_on,
  output logic                          out_pass_done,
  output logic [mks_pkg::CharW-1:0]     out_key_char,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mks_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [mks_pkg::TickW-1:0]     cfg_data
);
  import mks_pkg::*;

  cfg_t  cfg_r;
  res_t  res;
  res_t  res_r;
  logic  out_valid_r;
  logic  step;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign step      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_ticks       <= SETTLE_RST;
      cfg_r.debounce_ticks     <= DEBOUNCE_RST;
      cfg_r.beep_ticks         <= BEEP_RST;
      cfg_r.release_poll_ticks <= POLL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SETTLE:   cfg_r.settle_ticks       <= cfg_data;
        REG_DEBOUNCE: cfg_r.debounce_ticks     <= cfg_data;
        REG_BEEP:     cfg_r.beep_ticks         <= cfg_data;
        REG_POLL:     cfg_r.release_poll_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  mks_scan #(
    .ROW_COUNT(ROW_COUNT)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .col_sample (in_col_sample),
    .cfg        (cfg_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_drive = res_r.row_drive;
  assign out_beep_on   = res_r.beep_on;
  assign out_pass_done = res_r.pass_done;
  assign out_key_char  = res_r.key_char;

endmodule

// ----- src/mks_scan.sv -----
`timescale 1ns / 1ps

module mks_scan #(
  parameter int ROW_COUNT = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [mks_pkg::ColW-1:0]   col_sample,
  input  mks_pkg::cfg_t              cfg,
  output mks_pkg::res_t              res
);
  import mks_pkg::*;

  localparam int RowW = $clog2(ROW_COUNT);

  phase_t             phase_r, phase_nxt;
  logic [RowW-1:0]    row_r, row_nxt;
  logic [TickW-1:0]   timer_r, timer_nxt;
  logic [2:0]         first_r, first_nxt;
  logic [CharW-1:0]   pass_r, pass_nxt;

  col_code_t          cc;
  logic               row_end;
  logic               pass_wrap;
  logic               row_in_tab;
  logic [1:0]         row2;
  logic [CharW-1:0]   pass_upd;
  phase_t             ph_mid;
  logic [TickW-1:0]   tm_mid;

  assign cc         = decode_cols(col_sample);
  assign row_in_tab = (int'(row_r) < 4);
  assign row2       = 2'(row_r);
  assign pass_wrap  = (row_r == RowW'(ROW_COUNT - 1));

  // next state
  always_comb begin
    ph_mid    = phase_r;
    tm_mid    = timer_r;
    first_nxt = first_r;
    pass_upd  = pass_r;
    row_end   = 1'b0;
    unique case (phase_r)
      PH_SETTLE: begin
        if (timer_r < cfg.settle_ticks) begin
          tm_mid = timer_r + 1'b1;
        end else if (!cc.hit) begin
          row_end = 1'b1;
        end else begin
          first_nxt = cc.code;
          ph_mid    = PH_DEBOUNCE;
          tm_mid    = '0;
        end
      end
      PH_DEBOUNCE: begin
        if (timer_r < cfg.debounce_ticks) begin
          tm_mid = timer_r + 1'b1;
        end else if (cc.hit && cc.code == first_r) begin
          ph_mid = PH_BEEP;
          tm_mid = '0;
        end else begin
          row_end = 1'b1;
        end
      end
      PH_BEEP: begin
        if (timer_r < cfg.beep_ticks) begin
          tm_mid = timer_r + 1'b1;
        end else begin
          if (!first_r[2] && row_in_tab) begin
            pass_upd = key_lookup(row2, first_r[1:0]);
          end
          ph_mid = PH_RELEASE;
          tm_mid = cfg.release_poll_ticks;
        end
      end
      PH_RELEASE: ;
      default: ;
    endcase

    phase_nxt = ph_mid;
    timer_nxt = tm_mid;
    if (ph_mid == PH_RELEASE) begin
      if (tm_mid >= cfg.release_poll_ticks) begin
        if (!cc.hit) begin
          row_end = 1'b1;
        end else begin
          timer_nxt = TickW'(1);
        end
      end else begin
        timer_nxt = tm_mid + 1'b1;
      end
    end

    row_nxt  = row_r;
    pass_nxt = pass_upd;
    if (row_end) begin
      phase_nxt = PH_SETTLE;
      timer_nxt = '0;
      if (pass_wrap) begin
        row_nxt  = '0;
        pass_nxt = NO_KEY;
      end else begin
        row_nxt = row_r + 1'b1;
      end
    end
  end

  // outputs
  always_comb begin
    res.row_drive = row_in_tab ? ~(4'b0001 << row2) : ROWS_OFF;
    res.beep_on   = (phase_r == PH_BEEP) && (timer_r < cfg.beep_ticks);
    res.pass_done = row_end && pass_wrap;
    res.key_char  = pass_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SETTLE;
      row_r   <= '0;
      timer_r <= '0;
      first_r <= '0;
      pass_r  <= NO_KEY;
    end else if (step) begin
      phase_r <= phase_nxt;
      row_r   <= row_nxt;
      timer_r <= timer_nxt;
      first_r <= first_nxt;
      pass_r  <= pass_nxt;
    end
  end

endmodule
